// ----- sv/lptdac_pkg.sv -----
// Shared types, constants and a helper function for the parallel-port DAC block.
package lptdac_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] SILENT_LEVEL = 8'h80;
   localparam int         SELECT_BIT   = 3;
   localparam int         ACK_BIT      = 6;

   typedef enum logic [1:0] {
      OP_WRITE_DATA    = 2'd0,
      OP_READ_STATUS   = 2'd1,
      OP_WRITE_CONTROL = 2'd2,
      OP_RENDER        = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0]         read_data;
      logic signed [15:0] sample;
      logic               sample_valid;
   } rsp_type;

   // Advance a FIFO pointer, wrapping at the FIFO depth.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

// ----- sv/lpt_dac_fifo_sound_device_top.sv -----
// Top level of the parallel-port DAC with its sample FIFO.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+-------------------------------
//   req     | in        | req_valid / req_stall      | lptdac_pkg::req_type (op, value)
//   rsp     | out       | rsp_valid / rsp_stall      | lptdac_pkg::rsp_type
//   csr     | in        | csr_write_enable           | csr_write_data (status base)
//
// Every request transfer yields exactly one response, valid in the next cycle.
// A new request is taken every cycle while the response register is empty or is
// being drained in the same cycle; the single response register sets that.
// Reset is synchronous and active high; the FIFO then holds one silent entry,
// the data latch holds the silent level and the control byte is zero.
// A stalled response holds its payload, and req_stall is high only then.
module lpt_dac_fifo_sound_device_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lptdac_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lptdac_pkg::rsp_type rsp_payload,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data
);

   // Architectural state.
   logic [7:0]                   status_base_ff;
   logic [7:0]                   latched_byte_ff, latched_byte_in;
   logic [7:0]                   control_byte_ff, control_byte_in;
   logic [7:0]                   store_ff [lptdac_pkg::FIFO_DEPTH];
   logic [lptdac_pkg::CNT_W-1:0] count_ff, count_in;
   logic [lptdac_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lptdac_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   lptdac_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic       req_take;
   logic       fifo_full;
   logic       select_rise;
   logic       push;
   logic       pop;
   logic [7:0] front_byte;
   logic [7:0] status_byte;

   // The response register frees up either when empty or when its content
   // is transferred in this very cycle, so requests stream back to back.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   assign fifo_full   = (count_ff == lptdac_pkg::CNT_W'(lptdac_pkg::FIFO_DEPTH));
   assign select_rise = ~control_byte_ff[lptdac_pkg::SELECT_BIT]
                        & req_payload.value[lptdac_pkg::SELECT_BIT];

   // A push needs a rising edge of the select bit and room in the FIFO.
   // A pop never takes the last entry, so the DAC keeps its level.
   assign push = req_take & (req_payload.op == lptdac_pkg::OP_WRITE_CONTROL)
                 & select_rise & ~fifo_full;
   assign pop  = req_take & (req_payload.op == lptdac_pkg::OP_RENDER)
                 & (count_ff > lptdac_pkg::CNT_W'(1));

   assign front_byte = store_ff[rd_ptr_ff];

   // The status byte is the configured base with the ack bit showing FIFO full.
   always_comb begin
      status_byte                      = status_base_ff;
      status_byte[lptdac_pkg::ACK_BIT] = fifo_full;
   end

   always_comb begin
      latched_byte_in = latched_byte_ff;
      control_byte_in = control_byte_ff;
      count_in        = count_ff;
      rd_ptr_in       = rd_ptr_ff;
      wr_ptr_in       = wr_ptr_ff;

      if (req_take) begin
         unique case (req_payload.op)
            lptdac_pkg::OP_WRITE_DATA: begin
               latched_byte_in = req_payload.value;
            end
            lptdac_pkg::OP_WRITE_CONTROL: begin
               control_byte_in = req_payload.value;
            end
            lptdac_pkg::OP_READ_STATUS,
            lptdac_pkg::OP_RENDER: begin
            end
            default: begin
            end
         endcase
      end

      if (push) begin
         wr_ptr_in = lptdac_pkg::ptr_next(wr_ptr_ff);
         count_in  = count_ff + lptdac_pkg::CNT_W'(1);
      end
      if (pop) begin
         rd_ptr_in = lptdac_pkg::ptr_next(rd_ptr_ff);
         count_in  = count_ff - lptdac_pkg::CNT_W'(1);
      end
   end

   // Response formation: one result per request, fields zero where unused.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      if (req_take) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = '0;
         unique case (req_payload.op)
            lptdac_pkg::OP_READ_STATUS: begin
               rsp_payload_in.read_data = status_byte;
            end
            lptdac_pkg::OP_RENDER: begin
               // (byte - 128) * 256 is the byte with its top bit flipped, shifted up.
               rsp_payload_in.sample       = {~front_byte[7], front_byte[6:0], 8'h00};
               rsp_payload_in.sample_valid = 1'b1;
            end
            lptdac_pkg::OP_WRITE_DATA,
            lptdac_pkg::OP_WRITE_CONTROL: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_base_ff  <= 8'h00;
         latched_byte_ff <= lptdac_pkg::SILENT_LEVEL;
         control_byte_ff <= 8'h00;
         count_ff        <= lptdac_pkg::CNT_W'(1);
         rd_ptr_ff       <= '0;
         wr_ptr_ff       <= lptdac_pkg::PTR_W'(1);
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            status_base_ff <= csr_write_data;
         end
         latched_byte_ff <= latched_byte_in;
         control_byte_ff <= control_byte_in;
         count_ff        <= count_in;
         rd_ptr_ff       <= rd_ptr_in;
         wr_ptr_ff       <= wr_ptr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Sample store: only the first entry has a reset value, the silent level
   // that the FIFO holds out of reset. Other entries are read only once written.
   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff[0] <= lptdac_pkg::SILENT_LEVEL;
      end else if (push) begin
         store_ff[wr_ptr_ff] <= latched_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- sv/lptdac_checker.sv -----
// Port-level assertions for the parallel-port DAC top level, with its bind.
module lptdac_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input lptdac_pkg::req_type req_payload,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input lptdac_pkg::rsp_type rsp_payload
);

   // Requests are never held off while no response is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty response register");

   // Every request transfer shows up as a response in the next cycle, flagged
   // as a sample exactly when it was a render tick.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=>
         rsp_valid
         && (rsp_payload.sample_valid == ($past(req_payload.op) == lptdac_pkg::OP_RENDER)))
      else $error("request transfer without matching response");

   // A sample response carries no status byte, and a non-sample response no sample.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_payload.sample_valid ? (rsp_payload.read_data == 8'h00)
                                   : (rsp_payload.sample == 16'sh0000)))
      else $error("unused response field is not zero");

   // A stalled response stays and keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

endmodule

bind lpt_dac_fifo_sound_device_top lptdac_checker u_lptdac_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- dv/tb_lpt_dac_fifo_sound_device_top.sv -----
// Testbench for the parallel-port DAC top level with a self-checking sample FIFO scoreboard.
`timescale 1ns / 1ps

module tb_lpt_dac_fifo_sound_device_top;

   localparam logic [7:0] SELECT_MASK = 8'h01 << lptdac_pkg::SELECT_BIT;
   localparam logic [7:0] ACK_MASK    = 8'h01 << lptdac_pkg::ACK_BIT;
   // The limit lies well above the slowest legal run, so this is a wide margin.
   localparam int unsigned CYCLE_LIMIT = 300000;

   // The scoreboard mirrors the DAC state. Each accepted bus access updates the
   // mirror and queues the response it must produce; each response transfer is
   // checked against the oldest queued one.
   class dac_scoreboard;
      logic [7:0]                   status_base;
      logic [7:0]                   latched_byte;
      logic [7:0]                   control_byte;
      logic [7:0]                   sample_store [lptdac_pkg::FIFO_DEPTH];
      int unsigned                  entry_count;
      logic [lptdac_pkg::PTR_W-1:0] read_ptr;
      logic [lptdac_pkg::PTR_W-1:0] write_ptr;
      lptdac_pkg::rsp_type          predicted_q [$];
      int unsigned                  errors;

      function new();
         status_base  = 8'h00;
         latched_byte = lptdac_pkg::SILENT_LEVEL;
         control_byte = 8'h00;
         foreach (sample_store[i]) sample_store[i] = 8'h00;
         sample_store[0] = lptdac_pkg::SILENT_LEVEL;
         entry_count  = 1;
         read_ptr     = '0;
         write_ptr    = lptdac_pkg::PTR_W'(1);
         errors       = 0;
      endfunction

      function void note_access(lptdac_pkg::req_type req);
         lptdac_pkg::rsp_type predicted;
         logic [7:0]          front;
         logic [7:0]          status;
         bit                  rising;
         predicted = '0;
         case (req.op)
            lptdac_pkg::OP_WRITE_DATA: begin
               latched_byte = req.value;
            end
            lptdac_pkg::OP_READ_STATUS: begin
               // The ack bit reports a full FIFO and overrides the programmed bit.
               status = status_base & ~ACK_MASK;
               if (entry_count >= lptdac_pkg::FIFO_DEPTH) status = status | ACK_MASK;
               predicted.read_data = status;
            end
            lptdac_pkg::OP_WRITE_CONTROL: begin
               // Only a low-to-high change of the select bit pushes; a full FIFO
               // drops the push. The control byte is stored either way.
               rising = ((control_byte & SELECT_MASK) == 8'h00) &&
                        ((req.value & SELECT_MASK) != 8'h00);
               if (rising && entry_count < lptdac_pkg::FIFO_DEPTH) begin
                  sample_store[write_ptr] = latched_byte;
                  write_ptr = lptdac_pkg::PTR_W'((int'(write_ptr) + 1)
                                                 % lptdac_pkg::FIFO_DEPTH);
                  entry_count++;
               end
               control_byte = req.value;
            end
            default: begin
               // Render: unsigned byte to signed 16-bit, last entry is held.
               front = sample_store[read_ptr];
               predicted.sample       = {front ^ 8'h80, 8'h00};
               predicted.sample_valid = 1'b1;
               if (entry_count > 1) begin
                  read_ptr = lptdac_pkg::PTR_W'((int'(read_ptr) + 1)
                                                % lptdac_pkg::FIFO_DEPTH);
                  entry_count--;
               end
            end
         endcase
         predicted_q.push_back(predicted);
      endfunction

      function void check_output(lptdac_pkg::rsp_type rsp);
         lptdac_pkg::rsp_type want;
         if (predicted_q.size() == 0) begin
            $display("%0t: response with no access outstanding, actual %h", $time, rsp);
            errors++;
            return;
         end
         want = predicted_q.pop_front();
         if (rsp.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %h actual %h",
                     $time, want.read_data, rsp.read_data);
            errors++;
         end
         if (rsp.sample !== want.sample) begin
            $display("%0t: sample mismatch, expected %0d actual %0d",
                     $time, want.sample, rsp.sample);
            errors++;
         end
         if (rsp.sample_valid !== want.sample_valid) begin
            $display("%0t: sample_valid mismatch, expected %b actual %b",
                     $time, want.sample_valid, rsp.sample_valid);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return predicted_q.size();
      endfunction
   endclass

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   lptdac_pkg::req_type req_payload      = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   lptdac_pkg::rsp_type rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic [7:0]          csr_write_data   = 8'h00;

   dac_scoreboard sb = new();

   int unsigned cycle_count = 0;
   int unsigned items_sent  = 0;
   int unsigned burst_left  = 0;
   logic [7:0] stall_tick   = 8'h00;
   logic [1:0] stall_mode   = 2'd0;

   lpt_dac_fifo_sound_device_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Transfers are observed on the clock edge where they happen. The testbench
   // drives with nonblocking assignments, so the values read here are the ones
   // that were present just before the edge.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_access(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_output(rsp_payload);
      end
   end

   // The response side switches periodically between never stalling, light
   // random stalls, heavy random stalls and a fixed periodic stall run.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0:    rsp_stall <= 1'b0;
         2'd1:    rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2:    rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= (stall_tick[3:0] < 4'd6);
      endcase
   end

   // Present one access and return at the edge where it is taken. Valid is left
   // high so that a following access in the same burst can go out back to back.
   task automatic send_access(input lptdac_pkg::op_type op, input logic [7:0] value);
      lptdac_pkg::req_type access;
      access.op    = op;
      access.value = value;
      req_valid   <= 1'b1;
      req_payload <= access;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // The sender works in bursts; between bursts it drops valid for a while.
   // Some bursts follow the previous one with no gap at all.
   task automatic issue(input lptdac_pkg::op_type op, input logic [7:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      send_access(op, value);
   endtask

   // Stop sending, wait for every predicted response, then idle before returning.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_status_base(input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.status_base = value;
   endtask

   // A latch, clear-select, set-select triple always gives a select edge, so it pushes a
   // byte unless the FIFO is full; it dominates the fill mode.
   task automatic push_sample();
      logic [7:0] data;
      case ($urandom_range(0, 7))
         0:       data = 8'h00;
         1:       data = 8'hFF;
         2:       data = lptdac_pkg::SILENT_LEVEL;
         default: data = 8'($urandom_range(0, 255));
      endcase
      issue(lptdac_pkg::OP_WRITE_DATA, data);
      issue(lptdac_pkg::OP_WRITE_CONTROL, 8'($urandom_range(0, 255)) & ~SELECT_MASK);
      issue(lptdac_pkg::OP_WRITE_CONTROL, 8'($urandom_range(0, 255)) | SELECT_MASK);
   endtask

   // Fill mode drives the FIFO into its full state, drain mode empties it down
   // to the held entry, and mixed mode walks the pointers around the wrap.
   task automatic random_phase(input int unsigned count);
      int unsigned first;
      int unsigned mode;
      int unsigned mode_left;
      int unsigned pick;
      int unsigned push_lim;
      int unsigned render_lim;
      int unsigned read_lim;
      first     = items_sent;
      mode      = 0;
      mode_left = 0;
      push_lim  = 0;
      render_lim = 0;
      read_lim  = 0;
      while (items_sent - first < count) begin
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 40);
            case (mode)
               0: begin push_lim = 70; render_lim = 80; read_lim = 90; end
               1: begin push_lim = 10; render_lim = 70; read_lim = 80; end
               default: begin push_lim = 35; render_lim = 70; read_lim = 85; end
            endcase
         end
         mode_left--;
         pick = $urandom_range(0, 99);
         if (pick < push_lim) begin
            push_sample();
         end else if (pick < render_lim) begin
            repeat ($urandom_range(1, 4))
               issue(lptdac_pkg::OP_RENDER, 8'($urandom_range(0, 255)));
         end else if (pick < read_lim) begin
            issue(lptdac_pkg::OP_READ_STATUS, 8'($urandom_range(0, 255)));
         end else begin
            issue(lptdac_pkg::op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 199) == 0) drain();
      end
   endtask

   initial begin
      logic [7:0] phase_status [6];
      phase_status = '{8'hFF, 8'h00, 8'h40, 8'hBF, 8'h00, 8'h00};
      phase_status[4] = 8'($urandom_range(0, 255));
      phase_status[5] = 8'($urandom_range(0, 255));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the status base still at its reset value of zero.
      // A render right after reset outputs the silent entry and keeps it.
      issue(lptdac_pkg::OP_RENDER, 8'hFF);
      issue(lptdac_pkg::OP_RENDER, 8'h00);
      issue(lptdac_pkg::OP_READ_STATUS, 8'hFF);
      // Push the lowest byte on a select edge, then hold select high and let
      // it fall: neither of those may push.
      issue(lptdac_pkg::OP_WRITE_DATA, 8'h00);
      issue(lptdac_pkg::OP_WRITE_CONTROL, SELECT_MASK);
      issue(lptdac_pkg::OP_WRITE_CONTROL, 8'hFF);
      issue(lptdac_pkg::OP_WRITE_CONTROL, 8'h00);
      // A control write without the select bit must not push either.
      issue(lptdac_pkg::OP_WRITE_DATA, 8'hFF);
      issue(lptdac_pkg::OP_WRITE_CONTROL, ~SELECT_MASK);
      issue(lptdac_pkg::OP_WRITE_CONTROL, SELECT_MASK);
      // Drain silence, the most negative sample and the most positive one; the
      // last is held on the following render.
      issue(lptdac_pkg::OP_RENDER, 8'h00);
      issue(lptdac_pkg::OP_RENDER, 8'h00);
      issue(lptdac_pkg::OP_RENDER, 8'h00);
      issue(lptdac_pkg::OP_RENDER, 8'h00);
      issue(lptdac_pkg::OP_READ_STATUS, 8'h00);
      issue(lptdac_pkg::OP_WRITE_DATA, 8'h7F);
      issue(lptdac_pkg::OP_WRITE_CONTROL, 8'h00);
      issue(lptdac_pkg::OP_WRITE_CONTROL, 8'hFF);
      issue(lptdac_pkg::OP_RENDER, 8'hFF);
      issue(lptdac_pkg::OP_RENDER, 8'hFF);
      drain();

      // Random part: each phase runs with its own status base, written while
      // the block is idle. The fill mode also checks the ack bit at full.
      foreach (phase_status[i]) begin
         write_status_base(phase_status[i]);
         issue(lptdac_pkg::OP_READ_STATUS, 8'h00);
         random_phase(190);
         drain();
      end

      repeat (5) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $display("%0t: %0d predicted responses never arrived", $time, sb.outstanding());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
